>>> rtl/crs_pkg.sv
`default_nettype none

package crs_pkg;

    // Coordinate and segment-parameter formats
    localparam int COORD_BITS  = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_BITS      = T_FRAC_BITS + 1;

    // Extra fraction bits carried through the Horner chains
    localparam int GUARD_BITS  = 8;

    // Working width: coefficient sums reach 50 * 2^(COORD_BITS-1) before guard bits
    localparam int ACC_BITS    = COORD_BITS + GUARD_BITS + 7;
    localparam int DIFF_BITS   = COORD_BITS + 1;

    // Multiply by t is split into partial products of this many magnitude bits
    localparam int PART_BITS   = 24;
    localparam int NUM_PARTS   = (ACC_BITS + PART_BITS - 1) / PART_BITS;

    // Register stages inside one multiply-accumulate step
    localparam int MAC_STAGES  = 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [ACC_BITS-1:0]   t_acc;
    typedef logic        [ACC_BITS-1:0]   t_mag;
    typedef logic        [T_BITS-1:0]     t_frac;

    localparam t_frac T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    typedef struct packed {
        t_coord point_before;
        t_coord segment_start;
        t_coord segment_end;
        t_coord point_after;
        t_frac  fraction;
    } t_in;

    typedef struct packed {
        t_coord position;
        t_coord tangent;
    } t_out;

endpackage

`default_nettype wire

>>> rtl/crs_mac.sv
`default_nettype none

// One Horner step: o_h = round(i_h * i_t / 2^T_FRAC_BITS) + i_coef.
// Rounding is to nearest, ties away from zero (done on the magnitude).
// Stages: magnitude, partial products, combine + round, add coefficient.
module crs_mac (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire crs_pkg::t_acc i_h,
    input  wire crs_pkg::t_acc i_coef,
    input  wire crs_pkg::t_frac i_t,
    output logic               o_vld,
    output crs_pkg::t_acc      o_h,
    output crs_pkg::t_frac     o_t
);

    localparam int PAD_BITS  = crs_pkg::NUM_PARTS * crs_pkg::PART_BITS;
    localparam int PP_BITS   = crs_pkg::PART_BITS + crs_pkg::T_BITS;
    localparam int PROD_BITS = PAD_BITS + crs_pkg::T_BITS;

    // stage A: magnitude
    logic                r_a_vld;
    logic                r_a_neg;
    crs_pkg::t_mag       r_a_mag;
    crs_pkg::t_acc       r_a_coef;
    crs_pkg::t_frac      r_a_t;

    // stage M: partial products
    logic                r_m_vld;
    logic                r_m_neg;
    logic [PP_BITS-1:0]  r_m_pp [crs_pkg::NUM_PARTS];
    crs_pkg::t_acc       r_m_coef;
    crs_pkg::t_frac      r_m_t;

    // stage C: rounded product magnitude
    logic                r_c_vld;
    logic                r_c_neg;
    crs_pkg::t_mag       r_c_mag;
    crs_pkg::t_acc       r_c_coef;
    crs_pkg::t_frac      r_c_t;

    // stage S: signed result
    logic                r_s_vld;
    crs_pkg::t_acc       r_s_h;
    crs_pkg::t_frac      r_s_t;

    logic [PAD_BITS-1:0]  mag_pad;
    logic [PROD_BITS-1:0] n_sum;

    assign mag_pad = PAD_BITS'(r_a_mag);

    always_comb begin
        n_sum = PROD_BITS'(1) << (crs_pkg::T_FRAC_BITS - 1);
        for (int p = 0; p < crs_pkg::NUM_PARTS; p++) begin
            n_sum = n_sum + (PROD_BITS'(r_m_pp[p]) << (p * crs_pkg::PART_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_m_vld <= r_a_vld;
            r_c_vld <= r_m_vld;
            r_s_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg  <= i_h[crs_pkg::ACC_BITS-1];
            r_a_mag  <= i_h[crs_pkg::ACC_BITS-1] ? crs_pkg::t_mag'(-i_h) : crs_pkg::t_mag'(i_h);
            r_a_coef <= i_coef;
            r_a_t    <= i_t;

            r_m_neg  <= r_a_neg;
            for (int p = 0; p < crs_pkg::NUM_PARTS; p++) begin
                r_m_pp[p] <= PP_BITS'(mag_pad[p*crs_pkg::PART_BITS +: crs_pkg::PART_BITS])
                           * PP_BITS'(r_a_t);
            end
            r_m_coef <= r_a_coef;
            r_m_t    <= r_a_t;

            r_c_neg  <= r_m_neg;
            r_c_mag  <= n_sum[crs_pkg::T_FRAC_BITS +: crs_pkg::ACC_BITS];
            r_c_coef <= r_m_coef;
            r_c_t    <= r_m_t;

            r_s_h    <= r_c_neg ? r_c_coef - signed'(r_c_mag) : r_c_coef + signed'(r_c_mag);
            r_s_t    <= r_c_t;
        end
    end

    assign o_vld = r_s_vld;
    assign o_h   = r_s_h;
    assign o_t   = r_s_t;

endmodule

`default_nettype wire

>>> rtl/catmull_rom_spline_eval_top.sv
// Throughput: one beat per cycle; stalls only when output and skid registers both hold a beat.
// Pipeline: 3 coefficient stages, three 4-stage multiply-accumulate steps, 3 rounding stages.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`default_nettype none

module catmull_rom_spline_eval_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input channel
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire crs_pkg::t_in i_data,
    // output channel
    output logic              o_valid,
    input  wire logic         i_stall,
    output crs_pkg::t_out     o_data
);

    localparam int P1_DLY = 3 * crs_pkg::MAC_STAGES;
    localparam int LANES  = 2;   // lane 0: position, lane 1: tangent

    // ------------------------------------------------------------------
    // Pipeline advance. The whole pipe moves while the skid register is
    // empty; a beat that finds the output register stalled parks in the
    // skid, and only then does the input side see stall.
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic w_en;
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    // ------------------------------------------------------------------
    // C1: control-point differences, clamp t to one.
    //   e = p2-p0, f = p1-p2, g = p3-p0, k = p1-p0
    // ------------------------------------------------------------------
    logic            r_c1_vld;
    crs_pkg::t_diff  r_c1_e, r_c1_f, r_c1_g, r_c1_k;
    crs_pkg::t_coord r_c1_p1;
    crs_pkg::t_frac  r_c1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else if (w_en) begin
            r_c1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_e  <= crs_pkg::t_diff'(i_data.segment_end)   - crs_pkg::t_diff'(i_data.point_before);
            r_c1_f  <= crs_pkg::t_diff'(i_data.segment_start) - crs_pkg::t_diff'(i_data.segment_end);
            r_c1_g  <= crs_pkg::t_diff'(i_data.point_after)   - crs_pkg::t_diff'(i_data.point_before);
            r_c1_k  <= crs_pkg::t_diff'(i_data.segment_start) - crs_pkg::t_diff'(i_data.point_before);
            r_c1_p1 <= i_data.segment_start;
            r_c1_t  <= (i_data.fraction > crs_pkg::T_ONE) ? crs_pkg::T_ONE : i_data.fraction;
        end
    end

    // ------------------------------------------------------------------
    // C2: twice the cubic terms, d = g + 3f, c = -g - 4f - k
    // ------------------------------------------------------------------
    logic            r_c2_vld;
    crs_pkg::t_acc   r_c2_d, r_c2_c, r_c2_b2;
    crs_pkg::t_coord r_c2_p1;
    crs_pkg::t_frac  r_c2_t;
    crs_pkg::t_acc   f_ext, g_ext, k_ext;

    assign f_ext = crs_pkg::t_acc'(r_c1_f);
    assign g_ext = crs_pkg::t_acc'(r_c1_g);
    assign k_ext = crs_pkg::t_acc'(r_c1_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_vld <= 1'b0;
        end else if (w_en) begin
            r_c2_vld <= r_c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2_d  <= g_ext + f_ext + (f_ext <<< 1);
            r_c2_c  <= -g_ext - (f_ext <<< 2) - k_ext;
            r_c2_b2 <= crs_pkg::t_acc'(r_c1_e) <<< crs_pkg::GUARD_BITS;
            r_c2_p1 <= r_c1_p1;
            r_c2_t  <= r_c1_t;
        end
    end

    // ------------------------------------------------------------------
    // C3: guard-bit scaling, 3d for the tangent chain
    // ------------------------------------------------------------------
    logic            r_c3_vld;
    crs_pkg::t_acc   r_c3_d2, r_c3_d3, r_c3_c2, r_c3_b2;
    crs_pkg::t_coord r_c3_p1;
    crs_pkg::t_frac  r_c3_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3_vld <= 1'b0;
        end else if (w_en) begin
            r_c3_vld <= r_c2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3_d2 <= r_c2_d <<< crs_pkg::GUARD_BITS;
            r_c3_d3 <= (r_c2_d + (r_c2_d <<< 1)) <<< crs_pkg::GUARD_BITS;
            r_c3_c2 <= r_c2_c <<< crs_pkg::GUARD_BITS;
            r_c3_b2 <= r_c2_b2;
            r_c3_p1 <= r_c2_p1;
            r_c3_t  <= r_c2_t;
        end
    end

    // ------------------------------------------------------------------
    // Side delay lines: 2b for the second step, p1 for the final add
    // ------------------------------------------------------------------
    crs_pkg::t_acc   r_b2_dly [crs_pkg::MAC_STAGES];
    crs_pkg::t_coord r_p1_dly [P1_DLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b2_dly[0] <= r_c3_b2;
            for (int i = 1; i < crs_pkg::MAC_STAGES; i++) begin
                r_b2_dly[i] <= r_b2_dly[i-1];
            end
            r_p1_dly[0] <= r_c3_p1;
            for (int i = 1; i < P1_DLY; i++) begin
                r_p1_dly[i] <= r_p1_dly[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Position chain: h = ((2d t + 2c) t + 2b) t
    // ------------------------------------------------------------------
    logic           pos_vld1, pos_vld2, pos_vld3;
    crs_pkg::t_acc  pos_h1, pos_h2, pos_h3;
    crs_pkg::t_frac pos_t1, pos_t2, pos_t3;

    crs_mac u_pos_mac1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_c3_vld),
        .i_h     (r_c3_d2),
        .i_coef  (r_c3_c2),
        .i_t     (r_c3_t),
        .o_vld   (pos_vld1),
        .o_h     (pos_h1),
        .o_t     (pos_t1)
    );

    crs_mac u_pos_mac2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (pos_vld1),
        .i_h     (pos_h1),
        .i_coef  (r_b2_dly[crs_pkg::MAC_STAGES-1]),
        .i_t     (pos_t1),
        .o_vld   (pos_vld2),
        .o_h     (pos_h2),
        .o_t     (pos_t2)
    );

    crs_mac u_pos_mac3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (pos_vld2),
        .i_h     (pos_h2),
        .i_coef  ('0),
        .i_t     (pos_t2),
        .o_vld   (pos_vld3),
        .o_h     (pos_h3),
        .o_t     (pos_t3)
    );

    // ------------------------------------------------------------------
    // Tangent chain: g = (3*2d t + 2*2c) t + 2b, then delayed to line up
    // with the position chain's third step.
    // ------------------------------------------------------------------
    logic           tan_vld1, tan_vld2;
    crs_pkg::t_acc  tan_h1, tan_h2;
    crs_pkg::t_frac tan_t1, tan_t2;

    crs_mac u_tan_mac1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_c3_vld),
        .i_h     (r_c3_d3),
        .i_coef  (r_c3_c2 <<< 1),
        .i_t     (r_c3_t),
        .o_vld   (tan_vld1),
        .o_h     (tan_h1),
        .o_t     (tan_t1)
    );

    crs_mac u_tan_mac2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (tan_vld1),
        .i_h     (tan_h1),
        .i_coef  (r_b2_dly[crs_pkg::MAC_STAGES-1]),
        .i_t     (tan_t1),
        .o_vld   (tan_vld2),
        .o_h     (tan_h2),
        .o_t     (tan_t2)
    );

    crs_pkg::t_acc r_tan_dly  [crs_pkg::MAC_STAGES];
    logic          r_tan_vdly [crs_pkg::MAC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < crs_pkg::MAC_STAGES; i++) begin
                r_tan_vdly[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_tan_vdly[0] <= tan_vld2;
            for (int i = 1; i < crs_pkg::MAC_STAGES; i++) begin
                r_tan_vdly[i] <= r_tan_vdly[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tan_dly[0] <= tan_h2;
            for (int i = 1; i < crs_pkg::MAC_STAGES; i++) begin
                r_tan_dly[i] <= r_tan_dly[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final scaling: drop guard bits and the factor of two with
    // round-to-nearest (ties away from zero), add p1 on the position lane.
    // F1 magnitude, F2 round + shift, F3 signed add.
    // ------------------------------------------------------------------
    localparam crs_pkg::t_mag ROUND_HALF = crs_pkg::t_mag'(1) << crs_pkg::GUARD_BITS;

    crs_pkg::t_acc   lane_in [LANES];
    assign lane_in[0] = pos_h3;
    assign lane_in[1] = r_tan_dly[crs_pkg::MAC_STAGES-1];

    logic            r_f1_vld, r_f2_vld, r_f3_vld;
    logic            r_f1_neg [LANES];
    logic            r_f2_neg [LANES];
    crs_pkg::t_mag   r_f1_mag [LANES];
    crs_pkg::t_mag   r_f2_mag [LANES];
    crs_pkg::t_acc   r_f3_val [LANES];
    crs_pkg::t_coord r_f1_p1, r_f2_p1;
    crs_pkg::t_acc   lane_base [LANES];

    assign lane_base[0] = crs_pkg::t_acc'(r_f2_p1);
    assign lane_base[1] = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= pos_vld3;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_f1_neg[l] <= lane_in[l][crs_pkg::ACC_BITS-1];
                r_f1_mag[l] <= lane_in[l][crs_pkg::ACC_BITS-1] ? crs_pkg::t_mag'(-lane_in[l])
                                                               : crs_pkg::t_mag'(lane_in[l]);
                r_f2_neg[l] <= r_f1_neg[l];
                r_f2_mag[l] <= (r_f1_mag[l] + ROUND_HALF) >> (crs_pkg::GUARD_BITS + 1);
                r_f3_val[l] <= r_f2_neg[l] ? lane_base[l] - signed'(r_f2_mag[l])
                                           : lane_base[l] + signed'(r_f2_mag[l]);
            end
            r_f1_p1 <= r_p1_dly[P1_DLY-1];
            r_f2_p1 <= r_f1_p1;
        end
    end

    // saturate to the coordinate range: fits when the bits above the sign agree
    function automatic crs_pkg::t_coord sat_coord(input crs_pkg::t_acc v);
        logic [crs_pkg::ACC_BITS-crs_pkg::COORD_BITS:0] top;
        crs_pkg::t_coord res;
        top = v[crs_pkg::ACC_BITS-1:crs_pkg::COORD_BITS-1];
        if ((top == '0) || (top == '1)) begin
            res = v[crs_pkg::COORD_BITS-1:0];
        end else if (v[crs_pkg::ACC_BITS-1]) begin
            res = {1'b1, {(crs_pkg::COORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(crs_pkg::COORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    crs_pkg::t_out tail;
    assign tail.position = sat_coord(r_f3_val[0]);
    assign tail.tangent  = sat_coord(r_f3_val[1]);

    // ------------------------------------------------------------------
    // Output register with skid
    // ------------------------------------------------------------------
    crs_pkg::t_out r_out, r_skid;
    logic          r_out_v;
    logic          out_free;

    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_f3_vld;
            end
        end else if (r_f3_vld && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : tail;
        end else if (w_en) begin
            r_skid <= tail;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // tangent lane stays lined up with the position lane
    a_lane_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tan_vdly[crs_pkg::MAC_STAGES-1] == pos_vld3)
        else $error("tangent lane out of step with position lane");

    // skid holds a beat only behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid occupied while output register empty");

    // a finished beat meeting a stalled output must park in the skid
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall && r_f3_vld && !r_skid_v) |=> r_skid_v)
        else $error("finished beat dropped at stalled output");

    // t stays clamped to one at the end of both chains
    a_frac_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pos_vld3 || (pos_t3 <= crs_pkg::T_ONE))
        && (!tan_vld2 || (tan_t2 <= crs_pkg::T_ONE)))
        else $error("segment parameter above one inside a chain");

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    // Run size and guards
    localparam int NUM_ITEMS   = 1750;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_WAIT  = 40;       // pipeline is 18 deep plus output skid
    localparam int MAX_REPORTS = 10;

    localparam t_coord C_MAX = 32'sh7FFF_FFFF;
    localparam t_coord C_MIN = 32'sh8000_0000;
    localparam t_coord C_ONE = 32'sh0001_0000;  // 1.0 in Q16.16

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_out  o_data;

    catmull_rom_spline_eval_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Segments waiting to be sent, and curve samples waiting to come out
    t_in  segment_queue[$];
    t_out expected_samples[$];

    int   total_segments;
    int   beats_in;
    int   beats_out;
    int   mismatches;
    int   cycle_count;
    logic in_beat;       // input beat taken at the last rising edge
    int   sender_idle;   // percent of cycles the driver holds off
    int   receiver_idle; // percent of cycles the sink stalls

    // ------------------------------------------------------------------
    // Fixed-point curve evaluator
    // ------------------------------------------------------------------

    // h * t / 2^T_FRAC_BITS, rounded to nearest, ties away from zero
    function automatic longint mul_by_frac(longint h, bit [63:0] t);
        bit [63:0] mag;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] r;
        mag = (h < 0) ? 64'(-h) : 64'(h);
        hi  = mag >> 32;
        lo  = mag & 64'hFFFF_FFFF;
        r   = ((hi * t) << (32 - T_FRAC_BITS))
            + ((lo * t + (64'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS);
        return (h < 0) ? -longint'(r) : longint'(r);
    endfunction

    // v / 2^s, rounded to nearest, ties away from zero
    function automatic longint round_down_by(longint v, int s);
        bit [63:0] mag;
        bit [63:0] r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_coord clamp_coord(longint v);
        if (v > longint'(C_MAX)) begin
            return C_MAX;
        end
        if (v < longint'(C_MIN)) begin
            return C_MIN;
        end
        return t_coord'(v);
    endfunction

    function automatic t_out eval_segment(t_in seg);
        longint    p0, p1, p2, p3;
        longint    scale;
        longint    b2, c2, d2;
        longint    h, g;
        bit [63:0] t;
        t_out      res;
        p0    = longint'(seg.point_before);
        p1    = longint'(seg.segment_start);
        p2    = longint'(seg.segment_end);
        p3    = longint'(seg.point_after);
        scale = longint'(1) << GUARD_BITS;
        // anything past one is pinned to one
        t     = (seg.fraction > T_ONE) ? 64'(T_ONE) : 64'(seg.fraction);

        // doubled coefficients, with guard bits
        b2 = (p2 - p0) * scale;
        c2 = (2 * p0 - 5 * p1 + 4 * p2 - p3) * scale;
        d2 = (-p0 + 3 * p1 - 3 * p2 + p3) * scale;

        // position: p1 + (b t + c t^2 + d t^3)
        h = mul_by_frac(d2, t) + c2;
        h = mul_by_frac(h, t) + b2;
        h = mul_by_frac(h, t);
        res.position = clamp_coord(p1 + round_down_by(h, GUARD_BITS + 1));

        // tangent: b + 2 c t + 3 d t^2
        g = mul_by_frac(3 * d2, t) + 2 * c2;
        g = mul_by_frac(g, t) + b2;
        res.tangent = clamp_coord(round_down_by(g, GUARD_BITS + 1));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_segment(t_coord p0, t_coord p1, t_coord p2, t_coord p3,
                                        t_frac t);
        t_in seg;
        seg.point_before  = p0;
        seg.segment_start = p1;
        seg.segment_end   = p2;
        seg.point_after   = p3;
        seg.fraction      = t;
        segment_queue.push_back(seg);
    endfunction

    function automatic t_coord extreme_coord();
        case ($urandom_range(4))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // Mostly a point near the base, so the four points form a real curve
    function automatic t_coord near_coord(t_coord base);
        case ($urandom_range(9))
            0: return t_coord'($urandom);
            1: return extreme_coord();
            default: return base + ($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic t_frac random_frac();
        case ($urandom_range(15))
            0: return '0;
            1: return T_ONE;
            2: return t_frac'($urandom_range(32'(T_ONE) + 1, (1 << T_BITS) - 1));
            default: return t_frac'($urandom_range(0, 32'(T_ONE)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, phases
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Thirds of the run: slow sink, then slow source, then full rate
    always_comb begin
        if (beats_in < total_segments / 3) begin
            sender_idle   = 25;
            receiver_idle = 81;
        end else if (beats_in < 2 * total_segments / 3) begin
            sender_idle   = 81;
            receiver_idle = 25;
        end else begin
            sender_idle   = 0;
            receiver_idle = 0;
        end
    end

    // ------------------------------------------------------------------
    // Driver: one beat per handshake, payload held while stalled
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_beat) begin
            if (segment_queue.size() > 0 && $urandom_range(99) >= sender_idle) begin
                i_valid <= 1'b1;
                i_data  <= segment_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Sink back-pressure, independent of o_valid
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_idle);
        end
    end

    // Input side: each accepted segment yields exactly one expected sample
    always @(posedge i_clk) begin
        in_beat <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_samples.push_back(eval_segment(i_data));
            beats_in <= beats_in + 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output beat with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out <= beats_out + 1;
            if (expected_samples.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_REPORTS) begin
                    $display("[%0t] unexpected output beat: pos %0d tan %0d",
                             $realtime, o_data.position, o_data.tangent);
                end
            end else begin
                if (o_data !== expected_samples[0]) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS) begin
                        if (o_data.position !== expected_samples[0].position) begin
                            $display("[%0t] beat %0d position: expected %0d got %0d",
                                     $realtime, beats_out,
                                     expected_samples[0].position, o_data.position);
                        end
                        if (o_data.tangent !== expected_samples[0].tangent) begin
                            $display("[%0t] beat %0d tangent: expected %0d got %0d",
                                     $realtime, beats_out,
                                     expected_samples[0].tangent, o_data.tangent);
                        end
                    end
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d beats in, %0d out",
                     cycle_count, beats_in, total_segments, beats_out);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        t_coord base;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_data      = '0;
        in_beat     = 1'b0;
        beats_in    = 0;
        beats_out   = 0;
        mismatches  = 0;
        cycle_count = 0;

        // Directed: flat, extremes, saturation, straight line, t past one
        add_segment('0, '0, '0, '0, '0);
        add_segment(C_MAX, C_MAX, C_MAX, C_MAX, t_frac'(32768));
        add_segment(C_MIN, C_MIN, C_MIN, C_MIN, t_frac'(32768));
        add_segment(C_MIN, C_MAX, C_MIN, C_MAX, T_ONE);            // hard overflow
        add_segment(C_MAX, C_MIN, C_MAX, C_MIN, t_frac'(32768));
        add_segment(C_MIN, C_MAX, C_MIN, C_MAX, '0);
        add_segment(C_MAX, C_MAX, C_MIN, C_MIN, t_frac'(1));
        add_segment(C_MAX, C_MAX, C_MIN, C_MIN, t_frac'(65535));
        add_segment(C_MIN, C_MIN, C_MAX, C_MAX, t_frac'(49152));
        add_segment(C_MIN, '0, C_MAX, '0, t_frac'(21845));
        // evenly spaced points: position walks linearly, tangent stays at 1.0
        add_segment('0, C_ONE, 2 * C_ONE, 3 * C_ONE, '0);
        add_segment('0, C_ONE, 2 * C_ONE, 3 * C_ONE, t_frac'(16384));
        add_segment('0, C_ONE, 2 * C_ONE, 3 * C_ONE, t_frac'(32768));
        add_segment('0, C_ONE, 2 * C_ONE, 3 * C_ONE, T_ONE);
        // fraction field above one is pinned to one
        add_segment(-C_ONE, 5 * C_ONE, -3 * C_ONE, 7 * C_ONE, t_frac'(65537));
        add_segment(-C_ONE, 5 * C_ONE, -3 * C_ONE, 7 * C_ONE, t_frac'((1 << T_BITS) - 1));
        add_segment(-1, 1, -1, 1, t_frac'(3));
        add_segment(32'sh0000_8000, -32'sh0000_8000, 32'sh0000_8000, -32'sh0000_8000,
                    t_frac'(32767));
        add_segment(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 32'shCCCC_CCCC,
                    t_frac'(43690));

        // Random: mostly smooth curves, some wild points and extremes
        while (segment_queue.size() < NUM_ITEMS) begin
            base = ($urandom_range(3) == 0) ? t_coord'($urandom)
                                            : t_coord'($signed($urandom_range(0, 1 << 25))
                                                       - (1 << 24));
            add_segment(near_coord(base), near_coord(base), near_coord(base),
                        near_coord(base), random_frac());
        end
        total_segments = segment_queue.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (beats_in == total_segments);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d segments evaluated (%0d samples checked): directed extremes, overflow",
                 beats_in, beats_out);
        $display("and t past one, then random curves under three source/sink rate mixes.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatching beats", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
